[src/cplt_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Camera parameter tween package
// Shared types and constants for the camera parameter linear tween block.
// -----------------------------------------------------------------------------
package cplt_pkg;

  localparam int unsigned NumRegs  = 7;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned CfgW     = 32;
  localparam int unsigned DurW     = 8;
  localparam int unsigned NumDiv   = 9;
  localparam int unsigned DivSelW  = 4;
  // Dividend magnitude: 33-bit difference times 8-bit step.
  localparam int unsigned MagW     = 41;

  localparam logic [IdxW-1:0] RegDuration    = 3'd0;
  localparam logic [IdxW-1:0] RegTgtDistance = 3'd1;
  localparam logic [IdxW-1:0] RegTgtAngle    = 3'd2;
  localparam logic [IdxW-1:0] RegTgtPersp    = 3'd3;
  localparam logic [IdxW-1:0] RegTgtPosX     = 3'd4;
  localparam logic [IdxW-1:0] RegTgtPosY     = 3'd5;
  localparam logic [IdxW-1:0] RegTgtPosZ     = 3'd6;

  localparam logic ReqStart = 1'b0;
  localparam logic ReqTick  = 1'b1;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

endpackage

[src/cplt_div.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Shared restoring divider
// Signed dividend by unsigned 8-bit divisor, truncating toward zero, one
// quotient bit per cycle.
// -----------------------------------------------------------------------------
module cplt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [cplt_pkg::MagW:0] num_i,
  input  logic [cplt_pkg::DurW-1:0]     den_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic signed [cplt_pkg::MagW:0] quo_o
);

  localparam int unsigned W = cplt_pkg::MagW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]                  quo_q, quo_d;
  logic [cplt_pkg::DurW:0]       rem_q, rem_d;
  logic [cplt_pkg::DurW-1:0]     den_q, den_d;
  logic                          neg_q, neg_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [cplt_pkg::DurW:0]       trial;
  logic [W-1:0]                  mag;

  always_comb begin
    mag = num_i[W] ? W'(-num_i) : num_i[W-1:0];
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[cplt_pkg::DurW-1:0], quo_q[W-1]};
    if (start_i && !busy_q) begin
      quo_d  = mag;
      rem_d  = '0;
      den_d  = den_i;
      neg_d  = num_i[W];
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

[src/camera_param_linear_tween.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Camera parameter linear tween
// The result of a start or ignored item can be taken in the cycle after its
// transfer; that of an active tick once nine divisions have run in turn on one
// shared bit-serial divider and the output register has been loaded.
// The input is not ready until the result is taken, so the next
// transfer can follow in the cycle after the result transfer.
// Reset clears all control state and the configuration registers to zero.
// -----------------------------------------------------------------------------
module camera_param_linear_tween (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cplt_pkg::IdxW-1:0]    cfg_idx_i,
  input  logic [cplt_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // cur_distance, cur_angle, cur_perspective, cur_pos_x, cur_pos_y, cur_pos_z
  input  logic [159:0]                 s_axis_tdata,
  // req_type
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // distance_out, angle_out, perspective_out, offset_x, offset_y, offset_z
  output logic [159:0]                 m_axis_tdata,
  // update, done_res
  output logic [1:0]                   m_axis_tuser
);

  localparam int unsigned MW = cplt_pkg::MagW;

  typedef enum logic [2:0] {StIdle, StLoad, StWait, StOut} state_e;

  state_e state_q;
  logic [7:0]  dur_q;
  logic [31:0] tdist_q, tpx_q, tpy_q, tpz_q;
  logic [15:0] tang_q, tper_q;
  logic        active_q;
  logic [7:0]  step_q;
  logic [31:0] idist_q, ipx_q, ipy_q, ipz_q;
  logic [15:0] iang_q, iper_q;
  logic [cplt_pkg::DivSelW-1:0] sel_q;
  logic signed [MW:0] res_q [cplt_pkg::NumDiv];
  logic [159:0] odata_q;
  logic [1:0]   ouser_q;
  logic         ovalid_q;

  cplt_pkg::div_ctrl_t dctl;
  logic signed [MW:0] num, quo;
  logic signed [32:0] diff;
  logic [7:0]  mult;
  logic [7:0]  step_nx;

  always_comb begin
    case (sel_q)
      4'd0: diff = $signed({tdist_q[31], tdist_q}) - $signed({idist_q[31], idist_q});
      4'd1: diff = $signed({17'd0, tang_q}) - $signed({17'd0, iang_q});
      4'd2: diff = $signed({17'd0, tper_q}) - $signed({17'd0, iper_q});
      4'd3, 4'd4: diff = $signed({tpx_q[31], tpx_q}) - $signed({ipx_q[31], ipx_q});
      4'd5, 4'd6: diff = $signed({tpy_q[31], tpy_q}) - $signed({ipy_q[31], ipy_q});
      default: diff = $signed({tpz_q[31], tpz_q}) - $signed({ipz_q[31], ipz_q});
    endcase
    case (sel_q)
      4'd4, 4'd6, 4'd8: mult = step_q - 8'd1;
      default: mult = step_q;
    endcase
    num = $signed({{(MW - 32){diff[32]}}, diff}) * $signed({{(MW - 7){1'b0}}, mult});
  end

  assign dctl.start = (state_q == StLoad);

  cplt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dctl.start),
    .num_i   (num),
    .den_i   (dur_q),
    .busy_o  (dctl.busy),
    .done_o  (dctl.done),
    .quo_o   (quo)
  );

  assign s_axis_tready = (state_q == StIdle) && !ovalid_q;
  assign step_nx = step_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= '0; tdist_q <= '0; tang_q <= '0; tper_q <= '0;
      tpx_q <= '0; tpy_q <= '0; tpz_q <= '0;
      state_q <= StIdle; active_q <= 1'b0; step_q <= '0; sel_q <= '0;
      ovalid_q <= 1'b0; ouser_q <= '0; odata_q <= '0;
      idist_q <= '0; iang_q <= '0; iper_q <= '0;
      ipx_q <= '0; ipy_q <= '0; ipz_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cplt_pkg::RegDuration:    dur_q   <= cfg_data_i[7:0];
          cplt_pkg::RegTgtDistance: tdist_q <= cfg_data_i;
          cplt_pkg::RegTgtAngle:    tang_q  <= cfg_data_i[15:0];
          cplt_pkg::RegTgtPersp:    tper_q  <= cfg_data_i[15:0];
          cplt_pkg::RegTgtPosX:     tpx_q   <= cfg_data_i;
          cplt_pkg::RegTgtPosY:     tpy_q   <= cfg_data_i;
          cplt_pkg::RegTgtPosZ:     tpz_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            if (s_axis_tuser == cplt_pkg::ReqStart) begin
              if (!active_q && dur_q != 8'd0) begin
                active_q <= 1'b1;
                step_q   <= '0;
                idist_q  <= s_axis_tdata[31:0];
                iang_q   <= s_axis_tdata[47:32];
                iper_q   <= s_axis_tdata[63:48];
                ipx_q    <= s_axis_tdata[95:64];
                ipy_q    <= s_axis_tdata[127:96];
                ipz_q    <= s_axis_tdata[159:128];
                ouser_q  <= 2'b00;
              end else begin
                ouser_q  <= {!active_q, 1'b0};
              end
              odata_q  <= '0;
              ovalid_q <= 1'b1;
            end else if (!active_q) begin
              odata_q  <= '0;
              ouser_q  <= 2'b10;
              ovalid_q <= 1'b1;
            end else if (dur_q == 8'd0) begin
              active_q <= 1'b0;
              step_q   <= '0;
              odata_q  <= '0;
              ouser_q  <= 2'b10;
              ovalid_q <= 1'b1;
            end else begin
              step_q  <= step_nx;
              sel_q   <= '0;
              state_q <= StLoad;
            end
          end
        end
        StLoad: state_q <= StWait;
        StWait: begin
          if (dctl.done) begin
            res_q[sel_q] <= quo;
            if (sel_q == 4'(cplt_pkg::NumDiv - 1)) begin
              state_q <= StOut;
            end else begin
              sel_q   <= sel_q + 4'd1;
              state_q <= StLoad;
            end
          end
        end
        StOut: begin
          odata_q[31:0]    <= 32'($signed({idist_q[31], idist_q}) + res_q[0]);
          odata_q[47:32]   <= 16'({1'b0, iang_q} + res_q[1]);
          odata_q[63:48]   <= 16'({1'b0, iper_q} + res_q[2]);
          odata_q[95:64]   <= 32'(res_q[3] - res_q[4]);
          odata_q[127:96]  <= 32'(res_q[5] - res_q[6]);
          odata_q[159:128] <= 32'(res_q[7] - res_q[8]);
          if (step_q >= dur_q) begin
            active_q <= 1'b0;
            step_q   <= '0;
            ouser_q  <= 2'b11;
          end else begin
            ouser_q  <= 2'b01;
          end
          ovalid_q <= 1'b1;
          state_q  <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWait) |-> (dctl.busy || dctl.done)) else $error("divider idle while waiting");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !s_axis_tready) else $error("ready during work");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> !active_q) else $error("done while active");

endmodule

[bench/tb_camera_param_linear_tween.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Camera parameter linear tween testbench
// Drives start and tick transfers with bursty input and a stalling output,
// predicts every result from its own copy of the tween state and registers,
// and compares each output transfer field by field in order.
// -----------------------------------------------------------------------------
module tb_camera_param_linear_tween;

  typedef struct packed {
    logic        kind;
    logic [31:0] pz;
    logic [31:0] py;
    logic [31:0] px;
    logic [15:0] persp;
    logic [15:0] angle;
    logic [31:0] distance;
  } req_t;

  typedef struct packed {
    logic [1:0]  flags;
    logic [31:0] oz;
    logic [31:0] oy;
    logic [31:0] ox;
    logic [15:0] persp;
    logic [15:0] angle;
    logic [31:0] distance;
  } res_t;

  localparam int unsigned IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [cplt_pkg::IdxW-1:0] cfg_idx_i = '0;
  logic [cplt_pkg::CfgW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  camera_param_linear_tween u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Model of the tween.
  logic [7:0]  duration_r;
  logic [31:0] tgt_dist, tgt_px[3];
  logic [15:0] tgt_angle, tgt_persp;
  logic        tween_on;
  logic [7:0]  step_r;
  logic [31:0] from_dist, from_pos[3];
  logic [15:0] from_angle, from_persp;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   hold_off = 0;

  function automatic logic signed [63:0] tween_value(logic signed [63:0] a,
      logic signed [63:0] b, logic signed [63:0] s, logic signed [63:0] d);
    return a + ((b - a) * s) / d;
  endfunction

  function automatic res_t predict_tween(req_t r);
    res_t o;
    logic signed [63:0] s, d, diff, v;
    o = '0;
    if (r.kind == cplt_pkg::ReqStart) begin
      if (!tween_on && duration_r != 8'd0) begin
        tween_on = 1'b1;
        step_r = '0;
        from_dist = r.distance;
        from_angle = r.angle;
        from_persp = r.persp;
        from_pos[0] = r.px;
        from_pos[1] = r.py;
        from_pos[2] = r.pz;
      end
    end else if (tween_on) begin
      step_r = step_r + 8'd1;
      if (duration_r == 8'd0) begin
        tween_on = 1'b0;
        step_r = '0;
      end else begin
        s = $signed({56'd0, step_r});
        d = $signed({56'd0, duration_r});
        o.flags[0] = 1'b1;
        v = tween_value(64'($signed(from_dist)), 64'($signed(tgt_dist)), s, d);
        o.distance = v[31:0];
        v = tween_value({48'd0, from_angle}, {48'd0, tgt_angle}, s, d);
        o.angle = v[15:0];
        v = tween_value({48'd0, from_persp}, {48'd0, tgt_persp}, s, d);
        o.persp = v[15:0];
        for (int i = 0; i < 3; i++) begin
          diff = 64'($signed(tgt_px[i])) - 64'($signed(from_pos[i]));
          v = (diff * s) / d - (diff * (s - 1)) / d;
          if (i == 0) o.ox = v[31:0];
          else if (i == 1) o.oy = v[31:0];
          else o.oz = v[31:0];
        end
        if (step_r >= duration_r) begin
          tween_on = 1'b0;
          step_r = '0;
        end
      end
    end
    o.flags[1] = !tween_on;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // Driver: bursts of random length, random gaps.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_tween(pending_reqs.pop_front()));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_t nx;
          nx = pending_reqs[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= nx[159:0];
          s_axis_tuser <= nx.kind;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(8);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor with its own stall pattern.
  int stall_phase = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        res_t got, want;
        got = {m_axis_tuser, m_axis_tdata};
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer", 64'(got.flags), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.flags[0] !== want.flags[0])
            report_mismatch("update", 64'(got.flags[0]), 64'(want.flags[0]));
          if (got.flags[1] !== want.flags[1])
            report_mismatch("done", 64'(got.flags[1]), 64'(want.flags[1]));
          if (got.distance !== want.distance)
            report_mismatch("distance", 64'(got.distance), 64'(want.distance));
          if (got.angle !== want.angle)
            report_mismatch("angle", 64'(got.angle), 64'(want.angle));
          if (got.persp !== want.persp)
            report_mismatch("perspective", 64'(got.persp), 64'(want.persp));
          if (got.ox !== want.ox) report_mismatch("offset_x", 64'(got.ox), 64'(want.ox));
          if (got.oy !== want.oy) report_mismatch("offset_y", 64'(got.oy), 64'(want.oy));
          if (got.oz !== want.oz) report_mismatch("offset_z", 64'(got.oz), 64'(want.oz));
        end
      end
      stall_phase++;
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready <= 1'b0;
      end else if (stall_phase % 400 < 150) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(3) != 0);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t make_req(logic kind);
    req_t r;
    r.kind = kind;
    r.distance = pick32();
    r.angle = 16'($urandom);
    r.persp = 16'($urandom);
    r.px = pick32();
    r.py = pick32();
    r.pz = pick32();
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (450) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [cplt_pkg::IdxW-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      cplt_pkg::RegDuration: duration_r = val[7:0];
      cplt_pkg::RegTgtDistance: tgt_dist = val;
      cplt_pkg::RegTgtAngle: tgt_angle = val[15:0];
      cplt_pkg::RegTgtPersp: tgt_persp = val[15:0];
      cplt_pkg::RegTgtPosX: tgt_px[0] = val;
      cplt_pkg::RegTgtPosY: tgt_px[1] = val;
      default: tgt_px[2] = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_targets(logic [7:0] dur);
    write_reg(cplt_pkg::RegDuration, {24'd0, dur});
    write_reg(cplt_pkg::RegTgtDistance, pick32());
    write_reg(cplt_pkg::RegTgtAngle, $urandom);
    write_reg(cplt_pkg::RegTgtPersp, $urandom);
    write_reg(cplt_pkg::RegTgtPosX, pick32());
    write_reg(cplt_pkg::RegTgtPosY, pick32());
    write_reg(cplt_pkg::RegTgtPosZ, pick32());
  endtask

  initial begin
    int n;
    logic [7:0] dur;
    duration_r = '0; tgt_dist = '0; tgt_angle = '0; tgt_persp = '0;
    tween_on = 1'b0; step_r = '0; from_dist = '0; from_angle = '0; from_persp = '0;
    for (int i = 0; i < 3; i++) begin
      tgt_px[i] = '0;
      from_pos[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Idle tick, and start with zero duration.
    pending_reqs.push_back(make_req(cplt_pkg::ReqTick));
    pending_reqs.push_back(make_req(cplt_pkg::ReqStart));
    pending_reqs.push_back(make_req(cplt_pkg::ReqTick));
    wait_drained();

    // Extreme values over a short tween, with a start while active.
    write_reg(cplt_pkg::RegDuration, 32'd3);
    write_reg(cplt_pkg::RegTgtDistance, 32'h7fff_ffff);
    write_reg(cplt_pkg::RegTgtAngle, 32'h0000_ffff);
    write_reg(cplt_pkg::RegTgtPersp, 32'd0);
    write_reg(cplt_pkg::RegTgtPosX, 32'h7fff_ffff);
    write_reg(cplt_pkg::RegTgtPosY, 32'h8000_0000);
    write_reg(cplt_pkg::RegTgtPosZ, 32'h0000_0000);
    begin
      req_t r;
      r = make_req(cplt_pkg::ReqStart);
      r.distance = 32'h8000_0000; r.angle = '0; r.persp = 16'hffff;
      r.px = 32'h8000_0000; r.py = 32'h7fff_ffff; r.pz = 32'hffff_ffff;
      pending_reqs.push_back(r);
    end
    pending_reqs.push_back(make_req(cplt_pkg::ReqTick));
    pending_reqs.push_back(make_req(cplt_pkg::ReqStart));
    pending_reqs.push_back(make_req(cplt_pkg::ReqTick));
    pending_reqs.push_back(make_req(cplt_pkg::ReqTick));
    pending_reqs.push_back(make_req(cplt_pkg::ReqTick));
    wait_drained();

    // Duration cleared mid-tween, then lowered mid-tween.
    pending_reqs.push_back(make_req(cplt_pkg::ReqStart));
    pending_reqs.push_back(make_req(cplt_pkg::ReqTick));
    wait_drained();
    write_reg(cplt_pkg::RegDuration, 32'd0);
    pending_reqs.push_back(make_req(cplt_pkg::ReqTick));
    pending_reqs.push_back(make_req(cplt_pkg::ReqTick));
    wait_drained();
    write_reg(cplt_pkg::RegDuration, 32'd5);
    pending_reqs.push_back(make_req(cplt_pkg::ReqStart));
    pending_reqs.push_back(make_req(cplt_pkg::ReqTick));
    pending_reqs.push_back(make_req(cplt_pkg::ReqTick));
    pending_reqs.push_back(make_req(cplt_pkg::ReqTick));
    wait_drained();
    write_reg(cplt_pkg::RegDuration, 32'd2);
    pending_reqs.push_back(make_req(cplt_pkg::ReqTick));
    pending_reqs.push_back(make_req(cplt_pkg::ReqTick));
    wait_drained();

    // Largest duration, once.
    write_targets(8'd255);
    pending_reqs.push_back(make_req(cplt_pkg::ReqStart));
    for (int i = 0; i < 256; i++) pending_reqs.push_back(make_req(cplt_pkg::ReqTick));
    hold_off = 3000;
    wait_drained();

    // Random phases: mostly well-formed tweens, some noise.
    n = 0;
    while (n < 620) begin
      dur = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 12));
      write_targets(dur);
      for (int k = 0; k < 4; k++) begin
        pending_reqs.push_back(make_req(cplt_pkg::ReqStart));
        for (int t = 0; t < dur + 1; t++)
          pending_reqs.push_back(make_req($urandom_range(7) == 0 ?
                                          cplt_pkg::ReqStart : cplt_pkg::ReqTick));
        n += dur + 2;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
